### design/swmm_pkg.sv
// Shared types and constants for the sliding window min/max/sum unit.
`timescale 1ns / 1ps

package swmm_pkg;

   localparam int SAMPLE_W = 64;
   localparam int LEN_W    = 7;
   localparam int MODE_W   = 2;
   localparam int APB_W    = 32;
   localparam int PADDR_W  = 3;

   // reduction select codes
   localparam logic [MODE_W-1:0] MODE_SUM   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MIN   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MAX   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RANGE = 2'd3;

   // register index (byte address bit 2)
   localparam logic REG_WINDOW_LEN = 1'b0;
   localparam logic REG_MODE       = 1'b1;

   localparam logic [LEN_W-1:0]  WINDOW_LEN_RESET = 7'd1;
   localparam logic [MODE_W-1:0] MODE_RESET       = MODE_SUM;

   typedef struct packed {
      logic [LEN_W-1:0]  window_len;
      logic [MODE_W-1:0] mode;
   } cfg_type;

endpackage

### design/swmm_csr.sv
// APB register file holding window length and reduction mode.
`timescale 1ns / 1ps

module swmm_csr
   import swmm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [APB_W-1:0]   pwdata,
   output logic [APB_W-1:0]   prdata,
   output logic               pready,
   output cfg_type            cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    reg_index;
   logic    wr_en;

   assign reg_index = paddr[2];
   assign wr_en     = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_WINDOW_LEN: cfg_in.window_len = pwdata[LEN_W-1:0];
            REG_MODE:       cfg_in.mode       = pwdata[MODE_W-1:0];
            default:        cfg_in            = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_WINDOW_LEN: prdata = {{(APB_W-LEN_W){1'b0}}, cfg_ff.window_len};
         REG_MODE:       prdata = {{(APB_W-MODE_W){1'b0}}, cfg_ff.mode};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_len <= WINDOW_LEN_RESET;
         cfg_ff.mode       <= MODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### design/swmm_ring.sv
// Sample ring memory: one write port, one read port with registered data.
`timescale 1ns / 1ps

module swmm_ring
   import swmm_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
)(
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic signed [SAMPLE_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic signed [SAMPLE_W-1:0] rd_data
);

   logic signed [SAMPLE_W-1:0] mem [DEPTH];
   logic signed [SAMPLE_W-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

### design/sliding_window_min_max_sum_unit.sv
// Top level: sliding window sum / min / max / range over a signed sample stream.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | req_sample, req_restart
//   rsp     | out       | rsp_valid / rsp_stall | rsp_value
//   csr     | in        | APB psel/penable      | paddr, pwdata, prdata
//
// A request that completes a window passes through an accept/write step,
// one memory read per window entry (the window length being clamped to
// WINDOW_MAX), a drain step while the last read data lands and a finish
// step that forms the result. The single read port of the ring sets this.
// A request that yields no result ends with the accept/write step.
// Reset is synchronous; the ring memory is not cleared, since reads never
// go past the samples of the current series. A held result does not block
// the next request; only the finish step waits for the output register.
`timescale 1ns / 1ps

module sliding_window_min_max_sum_unit
   import swmm_pkg::*;
#(
   parameter int WINDOW_MAX = 64
)(
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_restart,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_value,
   // configuration port
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [PADDR_W-1:0]         paddr,
   input  logic [APB_W-1:0]           pwdata,
   output logic [APB_W-1:0]           prdata,
   output logic                       pready
);

   localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CW = $clog2(WINDOW_MAX + 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_READ   = 2'd1;
   localparam logic [1:0] S_DRAIN  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   cfg_type cfg;

   logic [1:0]                 state_ff, state_in;
   logic [AW-1:0]              write_slot_ff, write_slot_in;
   logic [CW-1:0]              fill_count_ff, fill_count_in;
   logic [AW-1:0]              rd_addr_ff, rd_addr_in;
   logic [CW-1:0]              remain_ff, remain_in;
   logic                       rd_valid_ff, rd_valid_in;
   logic signed [SAMPLE_W-1:0] sum_ff, sum_in;
   logic signed [SAMPLE_W-1:0] min_ff, min_in;
   logic signed [SAMPLE_W-1:0] max_ff, max_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_value_ff, rsp_value_in;

   logic                       req_accept;
   logic [AW-1:0]              newest;
   logic [CW-1:0]              len_eff;
   logic [CW-1:0]              fill_next;
   logic                       want_result;
   logic                       out_free;
   logic                       mem_rd_en;
   logic signed [SAMPLE_W-1:0] mem_rd_data;
   logic signed [SAMPLE_W-1:0] result;

   swmm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   swmm_ring #(
      .DEPTH (WINDOW_MAX),
      .AW    (AW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (newest),
      .wr_data (req_sample),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (mem_rd_data)
   );

   // Take a request only between windows; the sample goes straight to memory.
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && (state_ff == S_IDLE);
   assign mem_rd_en  = (state_ff == S_READ);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   // A restart puts this sample in slot 0 as the first of a new series.
   assign newest = req_restart ? '0 : write_slot_ff;

   // Clamp the programmed length to the ring depth.
   assign len_eff = (int'(cfg.window_len) > WINDOW_MAX) ? CW'(WINDOW_MAX)
                                                        : CW'(cfg.window_len);

   // Saturating fill count including this sample.
   assign fill_next = req_restart ? CW'(1)
                    : (fill_count_ff == CW'(WINDOW_MAX)) ? fill_count_ff
                    : fill_count_ff + CW'(1);

   assign want_result = (len_eff != '0) && (fill_next >= len_eff);

   always_comb begin
      case (cfg.mode)
         MODE_SUM:   result = sum_ff;
         MODE_MIN:   result = min_ff;
         MODE_MAX:   result = max_ff;
         default:    result = max_ff - min_ff;
      endcase
   end

   // Sequencer: write, walk the window backward from the newest slot, finish.
   always_comb begin
      state_in      = state_ff;
      write_slot_in = write_slot_ff;
      fill_count_in = fill_count_ff;
      rd_addr_in    = rd_addr_ff;
      remain_in     = remain_ff;
      rd_valid_in   = (state_ff == S_READ);
      sum_in        = sum_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;

      // fold in data returned by the previous read
      if (rd_valid_ff) begin
         sum_in = sum_ff + mem_rd_data;
         if (mem_rd_data < min_ff) begin
            min_in = mem_rd_data;
         end
         if (mem_rd_data > max_ff) begin
            max_in = mem_rd_data;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               write_slot_in = (newest == AW'(WINDOW_MAX - 1)) ? '0 : newest + AW'(1);
               fill_count_in = fill_next;
               if (want_result) begin
                  state_in   = S_READ;
                  rd_addr_in = newest;
                  remain_in  = len_eff;
                  sum_in     = '0;
                  min_in     = req_sample;
                  max_in     = req_sample;
               end
            end
         end
         S_READ: begin
            // step back one slot, wrapping below zero
            rd_addr_in = (rd_addr_ff == '0) ? AW'(WINDOW_MAX - 1) : rd_addr_ff - AW'(1);
            remain_in  = remain_ff - CW'(1);
            if (remain_ff == CW'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = result;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         write_slot_ff <= '0;
         fill_count_ff <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         write_slot_ff <= write_slot_in;
         fill_count_ff <= fill_count_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff   <= rd_addr_in;
      remain_ff    <= remain_in;
      sum_ff       <= sum_in;
      min_ff       <= min_in;
      max_ff       <= max_in;
      rsp_value_ff <= rsp_value_in;
   end

   // Read data only ever follows a read cycle.
   a_rd_after_read: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(state_ff == S_READ))
      else $error("read data without a read");

   // Fill count saturates at the ring depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      int'(fill_count_ff) <= WINDOW_MAX)
      else $error("fill count beyond ring depth");

   // Write pointer stays inside the ring.
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      int'(write_slot_ff) < WINDOW_MAX)
      else $error("write slot outside ring");

   // The walk never runs with nothing left to read.
   a_remain_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (remain_ff != '0))
      else $error("window walk with zero entries left");

   // A finished window lands in the output register once it is free.
   a_finish_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) && out_free |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("finished window not presented");

endmodule
